// ----- rtl/qsf_pkg.sv -----
// qsf_pkg: shared constants, types and the output rounding function
// of the q15 spatial filter core
// depends on nothing; imported by every module of the block but qsf_coef_ram
`default_nettype none

package qsf_pkg;

    // sizes of the filter
    localparam int MAX_CHANNELS   = 64;
    localparam int MAX_COMPONENTS = 8;
    localparam int CH_W           = $clog2(MAX_CHANNELS);
    localparam int COMP_W         = $clog2(MAX_COMPONENTS);
    localparam int ADDR_W         = COMP_W + CH_W;

    // data widths
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 38;
    localparam int Q_SHIFT  = 15;
    localparam int ROUND_HALF = 1 << 14;
    localparam int SHIFTED_W  = ACC_W + 1 - Q_SHIFT;

    // configuration port
    localparam int NCH_W      = 7;
    localparam int NCOMP_W    = 4;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COMPONENTS = 1'b1;

    localparam logic [NCH_W-1:0]   NCH_RESET   = NCH_W'(MAX_CHANNELS);
    localparam logic [NCOMP_W-1:0] NCOMP_RESET = NCOMP_W'(MAX_COMPONENTS);

    // request kinds
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // sequencer step counter
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] MAC_READS   = CNT_W'(MAX_COMPONENTS);
    localparam logic [CNT_W-1:0] SHIFT_FIRST = CNT_W'(2);
    localparam logic [CNT_W-1:0] MAC_LAST    = CNT_W'(MAX_COMPONENTS + 1);
    localparam logic [CNT_W-1:0] EMIT_LAST   = CNT_W'(MAX_COMPONENTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } seq_state_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic              rd_en;
        logic [COMP_W-1:0] rd_row;
        logic [CH_W-1:0]   rd_col;
        logic              shift;
        logic              clear;
        logic              emit;
        logic              emit_last;
        logic [COMP_W-1:0] emit_index;
    } seq_ctrl_t;

    // round half up, drop the fraction, saturate to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]       biased;
        logic signed [SHIFTED_W-1:0] shifted;
        logic signed [SHIFTED_W-1:0] sat_hi;
        logic signed [SHIFTED_W-1:0] sat_lo;
        logic signed [SAMPLE_W-1:0]  res;
        sat_hi  = SHIFTED_W'(32767);
        sat_lo  = -SHIFTED_W'(32768);
        biased  = {acc[ACC_W-1], acc} + (ACC_W+1)'(ROUND_HALF);
        shifted = biased[ACC_W:Q_SHIFT];
        if (shifted > sat_hi)
        begin
            res = 16'sh7fff;
        end
        else if (shifted < sat_lo)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = shifted[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/qsf_coef_ram.sv -----
// qsf_coef_ram: single write port, single read port coefficient memory
// with registered read data; no reset on the contents
// depends on nothing
`default_nettype none

module qsf_coef_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/qsf_acc_cell.sv -----
// qsf_acc_cell: one accumulator cell of the rotating accumulator chain
// depends on qsf_pkg
`default_nettype none

module qsf_acc_cell
    import qsf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    shift,
    input  wire logic signed [ACC_W-1:0] d,
    output logic signed      [ACC_W-1:0] q
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // take the neighbor's value on every chain step
    always_comb
    begin
        acc_next = shift ? d : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign q = acc_reg;

endmodule

`default_nettype wire

// ----- rtl/qsf_sequencer.sv -----
// qsf_sequencer: state machine that accepts requests, sweeps the
// coefficient rows per sample and steps the results out of the chain
// depends on qsf_pkg
`default_nettype none

module qsf_sequencer
    import qsf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               kind,
    input  wire logic [NCH_W-1:0]   eff_ch,
    input  wire logic [NCOMP_W-1:0] eff_comp,
    input  wire logic               out_free,
    output logic                    in_ready,
    output seq_ctrl_t               ctrl
);

    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CH_W-1:0]  pos_reg;
    logic [CH_W-1:0]  pos_next;
    logic [NCH_W-1:0] pos_inc;
    logic             in_comp;

    // state, step counter and channel position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
        end
    end

    // next state and control
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        in_ready        = 1'b0;
        pos_inc         = NCH_W'(pos_reg) + NCH_W'(1);
        in_comp         = cnt_reg < NCOMP_W'(eff_comp);
        ctrl            = '0;
        ctrl.rd_row     = cnt_reg[COMP_W-1:0];
        ctrl.rd_col     = pos_reg;
        ctrl.emit_index = cnt_reg[COMP_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && kind == KIND_SAMPLE)
                begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                end
            end
            ST_MAC:
            begin
                // read a row, multiply, then add into the chain head
                ctrl.rd_en = cnt_reg < MAC_READS;
                ctrl.shift = cnt_reg >= SHIFT_FIRST;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == MAC_LAST)
                begin
                    cnt_next = '0;
                    if (pos_inc < eff_ch)
                    begin
                        pos_next   = pos_inc[CH_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // rotate the chain once around, clearing behind the head
                ctrl.clear     = 1'b1;
                ctrl.emit      = in_comp && out_free;
                ctrl.emit_last = cnt_reg == (eff_comp - NCOMP_W'(1));
                ctrl.shift     = !in_comp || out_free;
                if (ctrl.shift)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == EMIT_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/q15_spatial_filter_core.sv -----
// q15_spatial_filter_core: Q15 spatial filter, a matrix-vector product
// over one multichannel timestep, built on a rotating accumulator chain
// depends on qsf_pkg, qsf_coef_ram, qsf_acc_cell, qsf_sequencer
//
// Usage
//   Input channel (in_valid/in_ready): a request with kind 0 writes one
//   coefficient (coef_component, coef_channel, coef_value).
//   A request with kind 1 carries the sample of the next channel.
//   Output channel (out_valid/out_ready): after the sample of the last
//   configured channel, one result per component, index 0 first, the
//   final one marked by last_component.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0: num_channels, 1: num_components); user keeps to idle, unchecked.
// Timing
//   A sample request is accepted in the idle state; then the single shared
//   multiplier walks the eight component rows of the coefficient memory
//   (one read per cycle, registered read, product register, add into the
//   chain head). After the last channel the chain rotates eight steps to
//   emit and clear, one result per cycle unless the receiver stalls.
// Reset and stall
//   Reset clears the accumulators and the channel position and sets the
//   registers (64 channels, 8 components); coefficients are undefined
//   until written. A stalled receiver holds the output register and the
//   emit sweep waits on it; no new request is taken until the sweep ends.
`default_nettype none

module q15_spatial_filter_core
    import qsf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    // input requests
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       kind,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [COMP_W-1:0]          coef_component,
    input  wire logic [CH_W-1:0]            coef_channel,
    input  wire logic signed [SAMPLE_W-1:0] coef_value,
    // results
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [COMP_W-1:0]               component_index,
    output logic signed [SAMPLE_W-1:0]      filtered_value,
    output logic                            last_component
);

    logic [NCH_W-1:0]   nch_reg;
    logic [NCH_W-1:0]   nch_next;
    logic [NCOMP_W-1:0] ncomp_reg;
    logic [NCOMP_W-1:0] ncomp_next;
    logic [NCH_W-1:0]   eff_ch;
    logic [NCOMP_W-1:0] eff_comp;

    seq_ctrl_t          ctrl;
    logic               in_accept;
    logic               out_free;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] x_next;
    logic signed [SAMPLE_W-1:0] coef_q;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;

    logic signed [ACC_W-1:0] acc_q [MAX_COMPONENTS];
    logic signed [ACC_W-1:0] acc_d [MAX_COMPONENTS];
    logic signed [ACC_W-1:0] head_sum;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [COMP_W-1:0]          out_index_reg;
    logic [COMP_W-1:0]          out_index_next;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic signed [SAMPLE_W-1:0] out_value_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    // configuration registers
    always_comb
    begin
        nch_next   = nch_reg;
        ncomp_next = ncomp_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_CHANNELS:   nch_next   = cfg_data[NCH_W-1:0];
                REG_NUM_COMPONENTS: ncomp_next = cfg_data[NCOMP_W-1:0];
                default:            nch_next   = nch_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch_reg   <= NCH_RESET;
            ncomp_reg <= NCOMP_RESET;
        end
        else
        begin
            nch_reg   <= nch_next;
            ncomp_reg <= ncomp_next;
        end
    end

    // clamp the counts into their usable ranges
    always_comb
    begin
        if (nch_reg == '0)
        begin
            eff_ch = NCH_W'(1);
        end
        else if (nch_reg > NCH_W'(MAX_CHANNELS))
        begin
            eff_ch = NCH_W'(MAX_CHANNELS);
        end
        else
        begin
            eff_ch = nch_reg;
        end

        if (ncomp_reg == '0)
        begin
            eff_comp = NCOMP_W'(1);
        end
        else if (ncomp_reg > NCOMP_W'(MAX_COMPONENTS))
        begin
            eff_comp = NCOMP_W'(MAX_COMPONENTS);
        end
        else
        begin
            eff_comp = ncomp_reg;
        end
    end

    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // control sequencer
    qsf_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .eff_ch   (eff_ch),
        .eff_comp (eff_comp),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // coefficient memory, row-major by component
    qsf_coef_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (SAMPLE_W)
    ) u_ram (
        .clk   (clk),
        .we    (in_accept && kind == KIND_COEF),
        .waddr ({coef_component, coef_channel}),
        .wdata (coef_value),
        .re    (ctrl.rd_en),
        .raddr ({ctrl.rd_row, ctrl.rd_col}),
        .rdata (coef_q)
    );

    // sample latch and shared multiplier
    always_comb
    begin
        x_next    = (in_accept && kind == KIND_SAMPLE) ? sample : x_reg;
        prod_next = PROD_W'(x_reg) * PROD_W'(coef_q);
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
    end

    // chain wiring: each cell takes its upper neighbor, the tail takes
    // the head plus the product, or zero while emitting
    assign head_sum = acc_q[0] + ACC_W'(prod_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_COMPONENTS - 1; i++)
        begin
            acc_d[i] = acc_q[i + 1];
        end
        acc_d[MAX_COMPONENTS - 1] = ctrl.clear ? '0 : head_sum;
    end

    for (genvar g = 0; g < MAX_COMPONENTS; g++)
    begin : g_cell
        qsf_acc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ctrl.shift),
            .d     (acc_d[g]),
            .q     (acc_q[g])
        );
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
            out_index_next = ctrl.emit_index;
            out_value_next = round_sat(acc_q[0]);
            out_last_next  = ctrl.emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign component_index = out_index_reg;
    assign filtered_value  = out_value_reg;
    assign last_component  = out_last_reg;

    // the chain never moves while requests are being taken
    a_idle_no_shift: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_ready |-> !ctrl.shift
    ) else $error("accumulator chain shifted while idle");

    // a result is only loaded when the output register is free
    a_emit_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (!out_valid || out_ready)
    ) else $error("result overwrote a pending output");

    // after the emit sweep the head and tail accumulators are back at zero
    a_sweep_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        $fell(ctrl.clear) |-> (acc_q[0] == '0 && acc_q[MAX_COMPONENTS - 1] == '0)
    ) else $error("accumulators not cleared after emit sweep");

endmodule

`default_nettype wire

// ----- tb/q15_spatial_filter_core_test.sv -----
// q15_spatial_filter_core_test: self-checking testbench of the q15 spatial filter core
// drives coefficient and sample requests, predicts every filter output and checks it
// depends on qsf_pkg and q15_spatial_filter_core
`timescale 1ns / 100ps

module q15_spatial_filter_core_test;
    import qsf_pkg::*;

    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 2000;
    // number of channel columns that the samples of any test reach
    localparam int FILL_CHANNELS = 4;

    typedef struct {
        logic [COMP_W-1:0]          comp_idx;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } filter_result_t;

    // block ports
    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COMP_W-1:0]          coef_component;
    logic [CH_W-1:0]            coef_channel;
    logic signed [SAMPLE_W-1:0] coef_value;
    logic                       out_valid;
    logic                       out_ready;
    logic [COMP_W-1:0]          component_index;
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       last_component;

    // predicted filter state
    logic signed [SAMPLE_W-1:0] coef_mem [MAX_COMPONENTS][MAX_CHANNELS];
    longint                     acc_rows [MAX_COMPONENTS];
    int                         chan_pos;
    logic [NCH_W-1:0]           nch_reg;
    logic [NCOMP_W-1:0]         ncomp_reg;

    // filter outputs still to come, oldest first
    filter_result_t pending_outputs [$];

    // traffic shaping and bookkeeping
    int idle_pct;
    int stall_pct;
    int error_count;
    int samples_sent;
    int coef_writes;
    int cfg_writes;
    int outputs_checked;
    int timesteps_done;
    int quiet_cycles;

    q15_spatial_filter_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .sample          (sample),
        .coef_component  (coef_component),
        .coef_channel    (coef_channel),
        .coef_value      (coef_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .component_index (component_index),
        .filtered_value  (filtered_value),
        .last_component  (last_component)
    );

    // clock
    always
    begin
        #5 clk = ~clk;
    end

    // round half up, drop the fraction, clamp to q15
    function automatic logic signed [SAMPLE_W-1:0] round_to_q15(input longint acc);
        longint r;
        r = (acc + longint'(ROUND_HALF)) >>> Q_SHIFT;
        if (r > 32767)
        begin
            r = 32767;
        end
        else if (r < -32768)
        begin
            r = -32768;
        end
        return SAMPLE_W'(r);
    endfunction

    // update the filter state for one accepted request and queue its outputs
    function automatic void apply_filter_step(
        input logic                       req_kind,
        input logic signed [SAMPLE_W-1:0] req_sample,
        input logic [COMP_W-1:0]          req_row,
        input logic [CH_W-1:0]            req_col,
        input logic signed [SAMPLE_W-1:0] req_value
    );
        int             ncols;
        int             nrows;
        filter_result_t r;
        if (req_kind == KIND_COEF)
        begin
            coef_mem[req_row][req_col] = req_value;
            coef_writes++;
            return;
        end
        samples_sent++;
        // every row accumulates, whatever the component count
        for (int k = 0; k < MAX_COMPONENTS; k++)
        begin
            acc_rows[k] += longint'(req_sample) * longint'(coef_mem[k][chan_pos]);
        end
        chan_pos++;
        ncols = (nch_reg == 0) ? 1 : ((nch_reg > MAX_CHANNELS) ? MAX_CHANNELS : nch_reg);
        if (chan_pos < ncols)
        begin
            return;
        end
        // timestep complete: one output per component
        nrows = (ncomp_reg == 0) ? 1
                : ((ncomp_reg > MAX_COMPONENTS) ? MAX_COMPONENTS : ncomp_reg);
        for (int k = 0; k < nrows; k++)
        begin
            r.comp_idx = COMP_W'(k);
            r.value    = round_to_q15(acc_rows[k]);
            r.last     = (k == nrows - 1);
            pending_outputs.push_back(r);
        end
        for (int k = 0; k < MAX_COMPONENTS; k++)
        begin
            acc_rows[k] = 0;
        end
        chan_pos = 0;
        timesteps_done++;
    endfunction

    // random q15 value with extra weight on the two extremes
    function automatic logic signed [SAMPLE_W-1:0] random_q15();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // one request on the input channel, with random idle cycles ahead of it
    task automatic send_request(
        input logic                       req_kind,
        input logic signed [SAMPLE_W-1:0] req_sample,
        input logic [COMP_W-1:0]          req_row,
        input logic [CH_W-1:0]            req_col,
        input logic signed [SAMPLE_W-1:0] req_value
    );
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        kind           = req_kind;
        sample         = req_sample;
        coef_component = req_row;
        coef_channel   = req_col;
        coef_value     = req_value;
        in_valid       = 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        apply_filter_step(req_kind, req_sample, req_row, req_col, req_value);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        send_request(KIND_SAMPLE, x, COMP_W'($urandom_range(0, 7)),
                     CH_W'($urandom_range(0, 63)), random_q15());
    endtask

    task automatic send_coef(
        input int                         row,
        input int                         col,
        input logic signed [SAMPLE_W-1:0] value
    );
        send_request(KIND_COEF, random_q15(), COMP_W'(row), CH_W'(col), value);
    endtask

    // drop valid, let every expected output arrive and the block go quiet
    task automatic wait_for_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        if (idx == REG_NUM_CHANNELS)
        begin
            nch_reg = data[NCH_W-1:0];
        end
        else
        begin
            ncomp_reg = data[NCOMP_W-1:0];
        end
        cfg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_registers(
        input logic [CFG_DATA_W-1:0] channels,
        input logic [CFG_DATA_W-1:0] components
    );
        wait_for_idle();
        write_register(REG_NUM_CHANNELS, channels);
        write_register(REG_NUM_COMPONENTS, components);
    endtask

    // mostly samples with random content, some coefficient writes mixed in
    task automatic random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_coef($urandom_range(0, 7), $urandom_range(0, 63), random_q15());
            end
            else
            begin
                send_sample(random_q15());
            end
        end
    endtask

    // load every column that a sample can reach so that no sample reads an
    // unwritten entry
    task automatic test_coefficient_fill();
        idle_pct  = 0;
        stall_pct = 0;
        for (int row = 0; row < MAX_COMPONENTS; row++)
        begin
            for (int col = 0; col < FILL_CHANNELS; col++)
            begin
                send_coef(row, col, random_q15());
            end
        end
    endtask

    // one channel per timestep: sample extremes, rounding ties and saturation
    task automatic test_single_channel_extremes();
        logic signed [SAMPLE_W-1:0] col0 [MAX_COMPONENTS];
        logic signed [SAMPLE_W-1:0] xs [6];
        col0 = '{16'sh8000, 16'sh7fff, 16'sd1, -16'sd1, 16'sd0, 16'sd16384, -16'sd16384,
                 16'sd12345};
        xs   = '{16'sh8000, 16'sh7fff, 16'sd16384, -16'sd16384, -16'sd16385, 16'sd0};
        set_registers(7'd1, 7'd8);
        for (int k = 0; k < MAX_COMPONENTS; k++)
        begin
            send_coef(k, 0, col0[k]);
        end
        foreach (xs[i])
        begin
            send_sample(xs[i]);
        end
    endtask

    // two full-scale channels drive both rails into saturation
    task automatic test_two_channel_saturation();
        set_registers(7'd2, 7'd8);
        send_coef(0, 1, 16'sh8000);
        send_coef(1, 1, 16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
    endtask

    // a coefficient written between two channels applies to the second one
    task automatic test_write_during_timestep();
        send_sample(16'sd1000);
        send_coef(2, 1, 16'sh8000);
        send_sample(16'sh8000);
    endtask

    // channel count lowered below the current position closes the timestep
    task automatic test_config_during_timestep();
        set_registers(7'd127, 7'd15);
        send_sample(random_q15());
        send_sample(random_q15());
        send_sample(random_q15());
        // upper data bits of the component register are dropped: acts as one
        set_registers(7'd2, 7'h70);
        send_sample(random_q15());
    endtask

    task automatic test_random_no_idling();
        set_registers(7'd4, 7'd8);
        idle_pct  = 0;
        stall_pct = 0;
        random_traffic(16);
    endtask

    task automatic test_random_sender_idle();
        set_registers(7'd1, 7'd3);
        idle_pct  = 76;
        stall_pct = 0;
        random_traffic(16);
    endtask

    task automatic test_random_receiver_stall();
        set_registers(7'd3, 7'd15);
        idle_pct  = 0;
        stall_pct = 76;
        random_traffic(16);
    endtask

    task automatic test_random_both_idle();
        set_registers(7'd0, 7'd0);
        idle_pct  = 35;
        stall_pct = 35;
        random_traffic(12);
        set_registers(7'd2, 7'd5);
        random_traffic(8);
    endtask

    // receiver readiness changes at the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each output with the oldest prediction
    always @(posedge clk)
    begin : check_outputs
        filter_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $display("%0t: unexpected output component %0d value %0d last %0b",
                         $time, component_index, filtered_value, last_component);
                error_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                outputs_checked++;
                if (component_index !== want.comp_idx)
                begin
                    $display("%0t: component_index expected %0d, got %0d",
                             $time, want.comp_idx, component_index);
                    error_count++;
                end
                if (filtered_value !== want.value)
                begin
                    $display("%0t: filtered_value of component %0d expected %0d, got %0d",
                             $time, want.comp_idx, want.value, filtered_value);
                    error_count++;
                end
                if (last_component !== want.last)
                begin
                    $display("%0t: last_component of component %0d expected %0b, got %0b",
                             $time, want.comp_idx, want.last, last_component);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request or output moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        // known values on every input, reset asserted
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_NUM_CHANNELS;
        cfg_data       = '0;
        in_valid       = 1'b0;
        kind           = KIND_SAMPLE;
        sample         = '0;
        coef_component = '0;
        coef_channel   = '0;
        coef_value     = '0;
        out_ready      = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        error_count    = 0;
        samples_sent   = 0;
        coef_writes    = 0;
        cfg_writes     = 0;
        outputs_checked = 0;
        timesteps_done = 0;
        quiet_cycles   = 0;
        chan_pos       = 0;
        nch_reg        = NCH_RESET;
        ncomp_reg      = NCOMP_RESET;
        for (int k = 0; k < MAX_COMPONENTS; k++)
        begin
            acc_rows[k] = 0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                coef_mem[k][c] = '0;
            end
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_coefficient_fill();
        test_single_channel_extremes();
        test_two_channel_saturation();
        test_write_during_timestep();
        test_config_during_timestep();
        test_random_no_idling();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        wait_for_idle();
        $display("covered %0d samples, %0d coefficient writes and %0d register writes",
                 samples_sent, coef_writes, cfg_writes);
        $display("checked %0d filter outputs over %0d timesteps, %0d mismatches",
                 outputs_checked, timesteps_done, error_count);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
